@@ hw/rtl/tktab_pkg.sv @@
// ----------------------------------------------------------------------------
// tktab_pkg
// Shared types and helpers for the top-k ranking table: entry layout,
// action codes, sequencer states and the rank order.
// ----------------------------------------------------------------------------
package tktab_pkg;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned COUNT_W = 7;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic [FIELD_W-1:0] score;
    logic [FIELD_W-1:0] time_used;
    logic [FIELD_W-1:0] tag;
  } entry_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_PLACE = 5'b10000
  } state_t;

  // True when the new record belongs strictly ahead of the held entry.
  function automatic logic ranks_before(input entry_t rec, input entry_t held);
    logic result;
    if (rec.score != held.score) begin
      result = (rec.score > held.score);
    end else begin
      result = (rec.time_used < held.time_used);
    end
    return result;
  endfunction

endpackage

@@ hw/rtl/tktab_ram.sv @@
// ----------------------------------------------------------------------------
// tktab_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module tktab_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/top_k_ranking_table.sv @@
// ----------------------------------------------------------------------------
// top_k_ranking_table
// Bounded table of records kept sorted best first (higher score, then lower
// time used). Inserts place a record at its rank; reads return one rank.
// ----------------------------------------------------------------------------
// Usage: pulse start with an item while busy is low. A read item addresses
// the table, then takes the registered entry. An insert item walks the
// table from its tail toward the head, one entry per cycle, moving each
// entry that the new record beats down by one place and writing the new
// record into the gap; with a full table it first checks the last entry,
// which decides drop or evict. The single table memory port pair sets the
// pace of the walk: each cycle reads one entry and writes the one shifted
// before it. Every item gives exactly one result, shown for one cycle with
// done high; the receiver cannot hold it off, and busy is already low
// during that cycle.
// Full ties go after the equal entries; a record that ranks last in a full
// table is dropped (placed low, rank zero). No clearing pass is needed after
// reset: the fill count alone decides which ranks hold entries.
// ----------------------------------------------------------------------------
module top_k_ranking_table
  import tktab_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [FIELD_W-1:0] score,
  input  logic [FIELD_W-1:0] time_used,
  input  logic [FIELD_W-1:0] record_tag,
  input  logic [RANK_W-1:0]  rank_index,
  output logic               done,
  output logic               placed,
  output logic [RANK_W-1:0]  rank,
  output logic               entry_valid,
  output logic [FIELD_W-1:0] out_score,
  output logic [FIELD_W-1:0] out_time,
  output logic [FIELD_W-1:0] out_tag,
  output logic [COUNT_W-1:0] entry_count
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > RANK_W) ? CW : RANK_W;

  state_t          state;
  state_t          state_next;
  logic [CW-1:0]   held_count;
  logic [AW-1:0]   cur;
  entry_t          new_entry;
  logic            rd_hit;
  logic [RANK_W-1:0] rd_rank;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic [AW-1:0]   mem_raddr;
  entry_t          mem_rdata;

  logic            take;
  logic            full;
  logic            beats;
  logic [CW-1:0]   count_inc;

  assign busy      = (state != ST_IDLE);
  assign take      = start && !busy;
  assign full      = (held_count == CW'(CAPACITY));
  assign beats     = ranks_before(new_entry, mem_rdata);
  assign count_inc = full ? held_count : held_count + CW'(1);

  tktab_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Table port control and next state.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = cur;
    mem_wdata  = new_entry;
    mem_raddr  = '0;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (action == ACT_READ) begin
            mem_raddr  = AW'(rank_index);
            state_next = ST_READ;
          end else if (full) begin
            // Look at the tail first: it decides drop or evict.
            mem_raddr  = AW'(CAPACITY - 1);
            state_next = ST_CHECK;
          end else if (held_count == '0) begin
            state_next = ST_PLACE;
          end else begin
            mem_raddr  = AW'(held_count - CW'(1));
            state_next = ST_SCAN;
          end
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      ST_CHECK: begin
        if (beats) begin
          mem_raddr  = AW'(CAPACITY - 2);
          state_next = ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        mem_we = 1'b1;
        if (beats) begin
          // Move the beaten entry down; prefetch the one above it.
          mem_wdata = mem_rdata;
          mem_raddr = cur - AW'(2);
          if (cur == AW'(1)) begin
            state_next = ST_PLACE;
          end
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PLACE: begin
        mem_we     = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer registers and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            new_entry <= '{score: score, time_used: time_used, tag: record_tag};
            rd_rank   <= rank_index;
            rd_hit    <= (XW'(rank_index) < XW'(held_count));
            cur       <= full ? AW'(CAPACITY - 1) : AW'(held_count);
          end
        end
        ST_READ: begin
          done        <= 1'b1;
          placed      <= 1'b0;
          rank        <= rd_rank;
          entry_valid <= rd_hit;
          out_score   <= rd_hit ? mem_rdata.score : '0;
          out_time    <= rd_hit ? mem_rdata.time_used : '0;
          out_tag     <= rd_hit ? mem_rdata.tag : '0;
          entry_count <= COUNT_W'(held_count);
        end
        ST_CHECK: begin
          if (!beats) begin
            // Drop: ranks last in a full table.
            done        <= 1'b1;
            placed      <= 1'b0;
            rank        <= '0;
            entry_valid <= 1'b0;
            out_score   <= '0;
            out_time    <= '0;
            out_tag     <= '0;
            entry_count <= COUNT_W'(held_count);
          end
        end
        ST_SCAN: begin
          if (beats) begin
            cur <= cur - AW'(1);
          end else begin
            held_count  <= count_inc;
            done        <= 1'b1;
            placed      <= 1'b1;
            rank        <= RANK_W'(cur);
            entry_valid <= 1'b0;
            out_score   <= '0;
            out_time    <= '0;
            out_tag     <= '0;
            entry_count <= COUNT_W'(count_inc);
          end
        end
        ST_PLACE: begin
          held_count  <= count_inc;
          done        <= 1'b1;
          placed      <= 1'b1;
          rank        <= RANK_W'(cur);
          entry_valid <= 1'b0;
          out_score   <= '0;
          out_time    <= '0;
          out_tag     <= '0;
          entry_count <= COUNT_W'(count_inc);
        end
        default: begin
        end
      endcase
    end
  end

  // A result appears only as the sequencer returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  // The fill count never exceeds the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(CAPACITY))
    else $error("held count beyond capacity");

  // An accepted item leaves the sequencer busy in the cycle after it is taken.
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    take |=> busy)
    else $error("accepted item did not start");

  // A kept insert leaves the table non-empty.
  a_placed_count: assert property (@(posedge clk) disable iff (rst)
    (done && placed) |-> (held_count != '0))
    else $error("insert placed but table empty");

  // The walk never reaches the head while still comparing.
  a_scan_cur: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cur != '0))
    else $error("scan pointer at head");

endmodule
